/* hdl/reaction_dependency_lister_assert.svh */
// Assertion macros for the reaction dependency lister.
`ifndef REACTION_DEPENDENCY_LISTER_ASSERT_SVH
`define REACTION_DEPENDENCY_LISTER_ASSERT_SVH

`ifndef SYNTH
`define RDL_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define RDL_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define RDL_ASSERT(lbl, clk, rstn, prop, msg)
`define RDL_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

/* hdl/rdl_pkg.sv */
// Shared constants for the reaction dependency lister.
package rdl_pkg;

  localparam int DEF_MAX_REACTIONS = 64;
  localparam int DEF_SPECIES       = 64;
  localparam int DEF_MAX_REACTANTS = 4;
  localparam int DEF_MAX_PRODUCTS  = 4;

  localparam int IDW  = 6;
  localparam int CNTW = 7;
  localparam int NUMW = 3;
  localparam int ADRW = 2;
  localparam int DATW = 32;

  localparam logic [ADRW-1:0] REG_REACTION_COUNT = ADRW'(0);

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

endpackage

/* hdl/reaction_dependency_lister.sv */
// Reaction dependency lister: species mask store and dependent-reaction scan.
// Load beat: written to both mask memories at acceptance, no result.
// Query beat: one reaction per cycle below the count, set by the single read
// port of the reactant mask memory, while no entry waits on a stalled output.
// An invalid query skips the scan. rst_n synchronous: control state and
// the count register clear; mask memories stay undefined until loaded.
module reaction_dependency_lister
  import rdl_pkg::*;
#(
  parameter int MAX_REACTIONS = DEF_MAX_REACTIONS,
  parameter int SPECIES       = DEF_SPECIES,
  parameter int MAX_REACTANTS = DEF_MAX_REACTANTS,
  parameter int MAX_PRODUCTS  = DEF_MAX_PRODUCTS
) (
  input  logic            clk,
  input  logic            rst_n,

  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [ADRW-1:0] paddr,
  input  logic [DATW-1:0] pwdata,
  output logic [DATW-1:0] prdata,
  output logic            pready,

  input  logic            in_valid,
  output logic            in_stall,
  input  logic            in_mode,
  input  logic [IDW-1:0]  in_reaction_index,
  input  logic [NUMW-1:0] in_num_reactants,
  input  logic [NUMW-1:0] in_num_products,
  input  logic [IDW-1:0]  in_reactant_0,
  input  logic [IDW-1:0]  in_reactant_1,
  input  logic [IDW-1:0]  in_reactant_2,
  input  logic [IDW-1:0]  in_reactant_3,
  input  logic [IDW-1:0]  in_product_0,
  input  logic [IDW-1:0]  in_product_1,
  input  logic [IDW-1:0]  in_product_2,
  input  logic [IDW-1:0]  in_product_3,

  output logic            out_valid,
  input  logic            out_stall,
  output logic [IDW-1:0]  out_queried_reaction,
  output logic [IDW-1:0]  out_dependent_reaction,
  output logic [IDW-1:0]  out_list_position,
  output logic            out_last_entry,
  output logic            out_invalid_query
);

  `include "reaction_dependency_lister_assert.svh"

  localparam int RW = $clog2(MAX_REACTIONS);
  localparam int SW = $clog2(SPECIES);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FLUSH, S_INV} state_t;

  state_t               state_r;
  logic [CNTW-1:0]      count_r;
  logic [IDW-1:0]       qidx_r;
  logic [RW-1:0]        cur_r;
  logic                 pend_v_r;
  logic [RW-1:0]        pend_b_r;
  logic [IDW-1:0]       pos_r;
  logic                 out_valid_r;
  logic [IDW-1:0]       out_q_r;
  logic [IDW-1:0]       out_d_r;
  logic [IDW-1:0]       out_p_r;
  logic                 out_last_r;
  logic                 out_inv_r;

  logic [SPECIES-1:0]   rmask_mem [MAX_REACTIONS];
  logic [SPECIES-1:0]   tmask_mem [MAX_REACTIONS];
  logic [SPECIES-1:0]   rdata_r;
  logic [SPECIES-1:0]   tdata_r;

  logic [CNTW-1:0]      cnt_eff;
  logic                 in_acc;
  logic                 ld_acc;
  logic                 q_acc;
  logic                 idx_ok;
  logic                 cfg_wr;
  logic [NUMW-1:0]      nr_c;
  logic [NUMW-1:0]      np_c;
  logic [IDW-1:0]       rsp [4];
  logic [IDW-1:0]       psp [4];
  logic [SPECIES-1:0]   rm_new;
  logic [SPECIES-1:0]   pm_new;
  logic                 hit;
  logic                 can_push;
  logic                 push;
  logic                 advance;
  logic                 last_scan;
  logic                 out_load;
  logic [RW-1:0]        rd_addr;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && (paddr == REG_REACTION_COUNT);
  assign prdata   = (paddr == REG_REACTION_COUNT) ? DATW'(count_r) : '0;

  assign cnt_eff  = (count_r > CNTW'(MAX_REACTIONS)) ? CNTW'(MAX_REACTIONS) : count_r;
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign ld_acc   = in_acc && (in_mode == MODE_LOAD) &&
                    ({1'b0, in_reaction_index} < CNTW'(MAX_REACTIONS));
  assign q_acc    = in_acc && (in_mode == MODE_QUERY);
  assign idx_ok   = {1'b0, in_reaction_index} < cnt_eff;

  assign rsp[0] = in_reactant_0;
  assign rsp[1] = in_reactant_1;
  assign rsp[2] = in_reactant_2;
  assign rsp[3] = in_reactant_3;
  assign psp[0] = in_product_0;
  assign psp[1] = in_product_1;
  assign psp[2] = in_product_2;
  assign psp[3] = in_product_3;

  assign nr_c = (in_num_reactants > NUMW'(MAX_REACTANTS)) ? NUMW'(MAX_REACTANTS)
                                                          : in_num_reactants;
  assign np_c = (in_num_products > NUMW'(MAX_PRODUCTS)) ? NUMW'(MAX_PRODUCTS)
                                                        : in_num_products;

  always_comb begin
    rm_new = '0;
    pm_new = '0;
    for (int i = 0; i < MAX_REACTANTS; i++) begin
      if ((NUMW'(i) < nr_c) && ({1'b0, rsp[i]} < CNTW'(SPECIES))) begin
        rm_new[rsp[i][SW-1:0]] = 1'b1;
      end
    end
    for (int i = 0; i < MAX_PRODUCTS; i++) begin
      if ((NUMW'(i) < np_c) && ({1'b0, psp[i]} < CNTW'(SPECIES))) begin
        pm_new[psp[i][SW-1:0]] = 1'b1;
      end
    end
  end

  // scan datapath: rdata_r holds reactant mask of reaction cur_r
  assign hit       = (qidx_r[RW-1:0] == cur_r) || (|(tdata_r & rdata_r));
  assign can_push  = !out_valid_r || !out_stall;
  assign push      = hit && pend_v_r;
  assign advance   = !push || can_push;
  assign last_scan = ({{(CNTW-RW){1'b0}}, cur_r} + CNTW'(1)) == cnt_eff;
  assign out_load  = can_push && (((state_r == S_SCAN) && push) ||
                                  (state_r == S_FLUSH) || (state_r == S_INV));

  always_comb begin
    case (state_r)
      S_SCAN:  rd_addr = advance ? cur_r + RW'(1) : cur_r;
      default: rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld_acc) begin
      rmask_mem[in_reaction_index[RW-1:0]] <= rm_new;
      tmask_mem[in_reaction_index[RW-1:0]] <= rm_new | pm_new;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= rmask_mem[rd_addr];
    if (q_acc) begin
      tdata_r <= tmask_mem[in_reaction_index[RW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        count_r <= pwdata[CNTW-1:0];
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (q_acc) begin
            qidx_r   <= in_reaction_index;
            cur_r    <= '0;
            pos_r    <= '0;
            pend_v_r <= 1'b0;
            state_r  <= idx_ok ? S_SCAN : S_INV;
          end
        end
        S_SCAN: begin
          if (advance) begin
            cur_r <= cur_r + RW'(1);
            if (hit) begin
              pend_v_r <= 1'b1;
              pend_b_r <= cur_r;
            end
            if (push) begin
              out_q_r     <= qidx_r;
              out_d_r     <= IDW'(pend_b_r);
              out_p_r     <= pos_r;
              out_last_r  <= 1'b0;
              out_inv_r   <= 1'b0;
              pos_r       <= pos_r + IDW'(1);
            end
            if (last_scan) begin
              state_r <= S_FLUSH;
            end
          end
        end
        S_FLUSH: begin
          if (can_push) begin
            out_q_r     <= qidx_r;
            out_d_r     <= IDW'(pend_b_r);
            out_p_r     <= pos_r;
            out_last_r  <= 1'b1;
            out_inv_r   <= 1'b0;
            pend_v_r    <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        S_INV: begin
          if (can_push) begin
            out_q_r     <= qidx_r;
            out_d_r     <= '0;
            out_p_r     <= '0;
            out_last_r  <= 1'b1;
            out_inv_r   <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid              = out_valid_r;
  assign out_queried_reaction   = out_q_r;
  assign out_dependent_reaction = out_d_r;
  assign out_list_position      = out_p_r;
  assign out_last_entry         = out_last_r;
  assign out_invalid_query      = out_inv_r;

  `RDL_ASSERT(a_inv_is_last, clk, rst_n,
    (out_valid && out_invalid_query) |-> out_last_entry, "invalid result not flagged last")
  `RDL_ASSERT(a_flush_has_pend, clk, rst_n,
    (state_r == S_FLUSH) |-> pend_v_r, "flush without pending entry")
  `RDL_ASSERT(a_more_to_come, clk, rst_n,
    (out_valid && !out_last_entry) |-> (state_r == S_SCAN || state_r == S_FLUSH),
    "list ended without last beat")
  `RDL_ASSERT(a_scan_in_range, clk, rst_n,
    (state_r == S_SCAN) |-> ({{(CNTW-RW){1'b0}}, cur_r} < cnt_eff), "scan index beyond count")

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the reaction dependency lister: loads, queries, count changes.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rdl_pkg::*;

  localparam int SETTLE_CYCLES = 70;
  localparam int STALL_LIMIT   = 4000;

  typedef struct packed {
    logic                      mode;
    logic [IDW-1:0]            reaction_index;
    logic [NUMW-1:0]           num_reactants;
    logic [NUMW-1:0]           num_products;
    logic [3:0][IDW-1:0]       reactants;
    logic [3:0][IDW-1:0]       products;
  } reaction_beat_t;

  typedef struct packed {
    logic [IDW-1:0] queried_reaction;
    logic [IDW-1:0] dependent_reaction;
    logic [IDW-1:0] list_position;
    logic           last_entry;
    logic           invalid_query;
  } dependency_entry_t;

  class dependency_board;
    logic [63:0]       reactant_mask [64];
    logic [63:0]       touched_mask [64];
    logic [CNTW-1:0]   reaction_count;
    dependency_entry_t pending_entries [$];
    int                errors;

    function new();
      reaction_count = '0;
      errors = 0;
      foreach (reactant_mask[i]) begin
        reactant_mask[i] = '0;
        touched_mask[i] = '0;
      end
    endfunction

    function void set_count(logic [CNTW-1:0] value);
      reaction_count = value;
    endfunction

    function logic [63:0] species_mask(logic [3:0][IDW-1:0] ids, int unsigned used);
      logic [63:0] m;
      m = '0;
      for (int i = 0; i < used; i++)
        if (ids[i] < DEF_SPECIES) m[ids[i]] = 1'b1;
      return m;
    endfunction

    // Loads update both masks; queries list dependents in ascending order.
    function void note_beat(reaction_beat_t b);
      int unsigned nr, np, eff, pos;
      logic [63:0] rm, tm;
      dependency_entry_t e;
      if (b.mode == MODE_LOAD) begin
        if (b.reaction_index >= DEF_MAX_REACTIONS) return;
        nr = (b.num_reactants > DEF_MAX_REACTANTS) ? DEF_MAX_REACTANTS : b.num_reactants;
        np = (b.num_products > DEF_MAX_PRODUCTS) ? DEF_MAX_PRODUCTS : b.num_products;
        rm = species_mask(b.reactants, nr);
        reactant_mask[b.reaction_index] = rm;
        touched_mask[b.reaction_index] = rm | species_mask(b.products, np);
        return;
      end
      eff = (reaction_count > DEF_MAX_REACTIONS) ? DEF_MAX_REACTIONS : reaction_count;
      e.queried_reaction = b.reaction_index;
      if (b.reaction_index >= eff) begin
        e.dependent_reaction = '0;
        e.list_position = '0;
        e.last_entry = 1'b1;
        e.invalid_query = 1'b1;
        pending_entries.push_back(e);
        return;
      end
      tm = touched_mask[b.reaction_index];
      pos = 0;
      e.last_entry = 1'b0;
      e.invalid_query = 1'b0;
      for (int r = 0; r < eff; r++) begin
        if (r == b.reaction_index || (tm & reactant_mask[r]) != '0) begin
          e.dependent_reaction = IDW'(r);
          e.list_position = IDW'(pos);
          pending_entries.push_back(e);
          pos++;
        end
      end
      pending_entries[pending_entries.size() - 1].last_entry = 1'b1;
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_entry(dependency_entry_t got);
      dependency_entry_t want;
      if (pending_entries.size() == 0) begin
        $display("%0t: unexpected result beat, actual %p", $time, got);
        errors++;
        return;
      end
      want = pending_entries.pop_front();
      compare_field("queried_reaction", want.queried_reaction, got.queried_reaction);
      compare_field("dependent_reaction", want.dependent_reaction, got.dependent_reaction);
      compare_field("list_position", want.list_position, got.list_position);
      compare_field("last_entry", want.last_entry, got.last_entry);
      compare_field("invalid_query", want.invalid_query, got.invalid_query);
    endfunction
  endclass

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            psel = 1'b0;
  logic            penable = 1'b0;
  logic            pwrite = 1'b0;
  logic [ADRW-1:0] paddr = '0;
  logic [DATW-1:0] pwdata = '0;
  logic [DATW-1:0] prdata;
  logic            pready;

  logic            in_valid = 1'b0;
  logic            in_stall;
  logic            in_mode = MODE_LOAD;
  logic [IDW-1:0]  in_reaction_index = '0;
  logic [NUMW-1:0] in_num_reactants = '0;
  logic [NUMW-1:0] in_num_products = '0;
  logic [IDW-1:0]  in_reactant_0 = '0;
  logic [IDW-1:0]  in_reactant_1 = '0;
  logic [IDW-1:0]  in_reactant_2 = '0;
  logic [IDW-1:0]  in_reactant_3 = '0;
  logic [IDW-1:0]  in_product_0 = '0;
  logic [IDW-1:0]  in_product_1 = '0;
  logic [IDW-1:0]  in_product_2 = '0;
  logic [IDW-1:0]  in_product_3 = '0;

  logic            out_valid;
  logic            out_stall = 1'b0;
  logic [IDW-1:0]  out_queried_reaction;
  logic [IDW-1:0]  out_dependent_reaction;
  logic [IDW-1:0]  out_list_position;
  logic            out_last_entry;
  logic            out_invalid_query;

  dependency_board board = new();
  logic [63:0]     loaded = '0;
  int unsigned     active_count = 0;
  int unsigned     send_idle_pct = 27;
  int unsigned     recv_idle_pct = 49;
  int unsigned     quiet_cycles = 0;

  reaction_dependency_lister dut (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .in_mode(in_mode),
    .in_reaction_index(in_reaction_index),
    .in_num_reactants(in_num_reactants), .in_num_products(in_num_products),
    .in_reactant_0(in_reactant_0), .in_reactant_1(in_reactant_1),
    .in_reactant_2(in_reactant_2), .in_reactant_3(in_reactant_3),
    .in_product_0(in_product_0), .in_product_1(in_product_1),
    .in_product_2(in_product_2), .in_product_3(in_product_3),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_queried_reaction(out_queried_reaction),
    .out_dependent_reaction(out_dependent_reaction),
    .out_list_position(out_list_position),
    .out_last_entry(out_last_entry), .out_invalid_query(out_invalid_query)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // result side: check accepted beats, stall at random
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_entry({out_queried_reaction, out_dependent_reaction, out_list_position,
                         out_last_entry, out_invalid_query});
    out_stall <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic reaction_beat_t random_load(int unsigned idx);
    reaction_beat_t b;
    bit narrow;
    narrow = ($urandom_range(3) != 0);
    b.mode = MODE_LOAD;
    b.reaction_index = IDW'(idx);
    b.num_reactants = NUMW'($urandom_range(7));
    b.num_products = NUMW'($urandom_range(7));
    for (int i = 0; i < 4; i++) begin
      b.reactants[i] = IDW'(narrow ? $urandom_range(15) : $urandom_range(63));
      b.products[i] = IDW'(narrow ? $urandom_range(15) : $urandom_range(63));
    end
    return b;
  endfunction

  function automatic reaction_beat_t query_beat(int unsigned idx);
    reaction_beat_t b;
    b = random_load(idx);
    b.mode = MODE_QUERY;
    return b;
  endfunction

  function automatic reaction_beat_t load_beat(int unsigned idx, int unsigned nr,
                                               int unsigned np,
                                               logic [3:0][IDW-1:0] r,
                                               logic [3:0][IDW-1:0] p);
    reaction_beat_t b;
    b.mode = MODE_LOAD;
    b.reaction_index = IDW'(idx);
    b.num_reactants = NUMW'(nr);
    b.num_products = NUMW'(np);
    b.reactants = r;
    b.products = p;
    return b;
  endfunction

  // most queries stay below the count, where all indices are loaded; the rest pick any index
  function automatic reaction_beat_t random_beat();
    if ($urandom_range(99) >= 55) return random_load($urandom_range(63));
    if (active_count != 0 && $urandom_range(9) < 8)
      return query_beat($urandom_range(active_count - 1));
    return query_beat($urandom_range(63));
  endfunction

  task automatic send_beat(input reaction_beat_t b);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= b.mode;
    in_reaction_index <= b.reaction_index;
    in_num_reactants <= b.num_reactants;
    in_num_products <= b.num_products;
    in_reactant_0 <= b.reactants[0];
    in_reactant_1 <= b.reactants[1];
    in_reactant_2 <= b.reactants[2];
    in_reactant_3 <= b.reactants[3];
    in_product_0 <= b.products[0];
    in_product_1 <= b.products[1];
    in_product_2 <= b.products[2];
    in_product_3 <= b.products[3];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_beat(b);
    if (b.mode == MODE_LOAD) loaded[b.reaction_index] = 1'b1;
  endtask

  task automatic drain_lists();
    in_valid <= 1'b0;
    while (board.pending_entries.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reaction_count(input logic [CNTW-1:0] value);
    drain_lists();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_REACTION_COUNT;
    pwdata <= DATW'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    board.set_count(value);
    active_count = (value > DEF_MAX_REACTIONS) ? DEF_MAX_REACTIONS : value;
  endtask

  initial begin
    int unsigned phase_counts [9];
    phase_counts = '{64, 2, 127, 17, 65, 0, 1, 40, 64};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // count zero after reset: every query is invalid
    send_beat(query_beat(0));
    send_beat(query_beat(63));
    send_beat(load_beat(0, 1, 1, {6'd9, 6'd9, 6'd9, 6'd0}, {6'd9, 6'd9, 6'd9, 6'd63}));
    // species field counts above four are clamped
    send_beat(load_beat(1, 7, 7, {6'd3, 6'd2, 6'd1, 6'd63}, {6'd7, 6'd6, 6'd5, 6'd4}));
    send_beat(load_beat(2, 0, 0, {4{6'd63}}, {4{6'd63}}));
    send_beat(load_beat(3, 2, 4, {6'd63, 6'd63, 6'd12, 6'd10},
                        {6'd0, 6'd22, 6'd21, 6'd20}));
    send_beat(load_beat(63, 4, 0, {6'd31, 6'd32, 6'd63, 6'd0}, {4{6'd1}}));
    set_reaction_count(CNTW'(4));
    for (int q = 0; q < 5; q++) send_beat(query_beat(q));
    send_beat(query_beat(63));
    set_reaction_count(CNTW'(1));
    send_beat(query_beat(0));
    send_beat(query_beat(1));

    for (int p = 0; p < 9; p++) begin
      if (p == 3) begin
        send_idle_pct = 49;
        recv_idle_pct = 27;
      end
      if (p == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      set_reaction_count(CNTW'(phase_counts[p]));
      for (int i = 0; i < active_count; i++)
        if (!loaded[i]) send_beat(random_load(i));
      repeat (44) send_beat(random_beat());
    end

    drain_lists();
    if (board.errors == 0 && board.pending_entries.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end
endmodule

/* files.f */
+incdir+hdl
hdl/rdl_pkg.sv
hdl/reaction_dependency_lister.sv
dv/testbench.sv
